FILE: hdl/q2e_pkg.sv
// Shared widths, angle constants and elaboration-time helpers for the quaternion-to-Euler block.
`default_nettype none
package q2e_pkg;

    // Q30 product after the floor shift, and the width of the summed terms
    localparam int PROD_W = 34;
    localparam int SUM_W  = 38;
    // Unit-range arcsine argument and radicand widths
    localparam int S_W    = 32;
    localparam int SQ_W   = 61;
    localparam int RES_W  = 62;
    localparam int SQRT_N = 31;
    // Prescaled vector, CORDIC datapath and Q56 angle accumulator widths
    localparam int PS_W   = 32;
    localparam int CW     = 36;
    localparam int ZW     = 61;
    localparam int PS_MAX = 7;
    localparam int PS_SEL_W = 3;

    localparam logic signed [ZW-1:0] PI_Q56         = 61'sh3243F6A8885A309;
    localparam logic signed [ZW-1:0] QUARTER_PI_Q56 = 61'shC90FDAA22168C2;
    localparam logic signed [SUM_W-1:0] ONE_Q30     = 38'sd1073741824;
    localparam logic signed [SUM_W-1:0] LIM31       = 38'sd2147483648;

    // Quotient of 2^e by a small odd number, by shift and subtract
    function automatic logic [63:0] pow2_div(input int e, input logic [7:0] dv);
        logic [63:0] q;
        logic [64:0] r;
        q = '0;
        r = '0;
        for (int b = 63; b >= 0; b--)
        begin
            r = {r[63:0], (b == e) ? 1'b1 : 1'b0};
            if (r >= {57'd0, dv})
            begin
                r    = r - {57'd0, dv};
                q[b] = 1'b1;
            end
        end
        return q;
    endfunction

    // atan(2^-i) in Q56 radians, from its power series in Q62
    function automatic logic signed [ZW-1:0] atan_q56(input int i);
        logic signed [63:0] sum;
        logic [63:0]        term;
        int                 e;
        sum = '0;
        if (i == 0)
        begin
            return QUARTER_PI_Q56;
        end
        for (int k = 0; k < 64; k++)
        begin
            e = 62 - i * (2 * k + 1);
            if (e >= 0)
            begin
                term = pow2_div(e, 8'(2 * k + 1));
                if (k % 2 == 1)
                    sum = sum - $signed(term);
                else
                    sum = sum + $signed(term);
            end
        end
        sum = (sum + 64'sd32) >>> 6;
        return sum[ZW-1:0];
    endfunction

    // True when the magnitude is below 2^31
    function automatic logic fits31(input logic signed [SUM_W-1:0] v);
        return (v < LIM31) && (v > -LIM31);
    endfunction

endpackage
`default_nettype wire

FILE: hdl/quaternion_to_euler_angles_top.sv
// Top level: quaternion products, arcsine radicand root and three angle pipelines.
//
// Fully pipelined: one quaternion beat may be taken every clock cycle and busy is
// always low. A beat with quat_present high yields one result beat, marked by done;
// a beat with quat_present low yields nothing. The latency is set by the 31-stage
// square root for the roll cosine, the CORDIC stages and the divide-by-five stages
// of the degree scaling. Results appear in arrival order, each for one cycle only;
// the receiver must take it then.
`default_nettype none
module quaternion_to_euler_angles_top
    import q2e_pkg::*;
#(
    parameter int CORDIC_STEPS    = 24,
    parameter int ANGLE_FRAC_BITS = 16
)(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire logic               quat_present,
    input  wire logic signed [31:0] quat_w,
    input  wire logic signed [31:0] quat_x,
    input  wire logic signed [31:0] quat_y,
    input  wire logic signed [31:0] quat_z,
    output logic                    done,
    output logic signed [23:0]      roll_deg,
    output logic signed [24:0]      pitch_deg,
    output logic signed [24:0]      yaw_deg
);

    assign busy = 1'b0;

    // Stage 1: ten products, floored to Q30
    logic signed [63:0] m_wy, m_xz, m_yz, m_wx, m_xx, m_yy, m_xy, m_wz, m_ww, m_zz;
    logic signed [PROD_W-1:0] p_wy_reg, p_xz_reg, p_yz_reg, p_wx_reg, p_xx_reg;
    logic signed [PROD_W-1:0] p_yy_reg, p_xy_reg, p_wz_reg, p_ww_reg, p_zz_reg;
    logic v1_reg;

    assign m_wy = quat_w * quat_y;
    assign m_xz = quat_x * quat_z;
    assign m_yz = quat_y * quat_z;
    assign m_wx = quat_w * quat_x;
    assign m_xx = quat_x * quat_x;
    assign m_yy = quat_y * quat_y;
    assign m_xy = quat_x * quat_y;
    assign m_wz = quat_w * quat_z;
    assign m_ww = quat_w * quat_w;
    assign m_zz = quat_z * quat_z;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v1_reg <= 1'b0;
        else
            v1_reg <= start && !busy && quat_present;
    end

    always_ff @(posedge clk)
    begin
        p_wy_reg <= m_wy[63:30];
        p_xz_reg <= m_xz[63:30];
        p_yz_reg <= m_yz[63:30];
        p_wx_reg <= m_wx[63:30];
        p_xx_reg <= m_xx[63:30];
        p_yy_reg <= m_yy[63:30];
        p_xy_reg <= m_xy[63:30];
        p_wz_reg <= m_wz[63:30];
        p_ww_reg <= m_ww[63:30];
        p_zz_reg <= m_zz[63:30];
    end

    // Stage 2: sums and arcsine argument saturation
    logic signed [SUM_W-1:0] s_raw, s_sat, py_next, px_next, yy_next, yx_next;
    logic signed [S_W-1:0]   s2_reg;
    logic signed [SUM_W-1:0] py2_reg, px2_reg, yy2_reg, yx2_reg;
    logic v2_reg;

    always_comb
    begin
        s_raw   = (SUM_W'(p_wy_reg) - SUM_W'(p_xz_reg)) <<< 1;
        s_sat   = (s_raw > ONE_Q30) ? ONE_Q30 : ((s_raw < -ONE_Q30) ? -ONE_Q30 : s_raw);
        py_next = (SUM_W'(p_yz_reg) + SUM_W'(p_wx_reg)) <<< 1;
        px_next = ONE_Q30 - ((SUM_W'(p_xx_reg) + SUM_W'(p_yy_reg)) <<< 1);
        yy_next = (SUM_W'(p_xy_reg) + SUM_W'(p_wz_reg)) <<< 1;
        yx_next = SUM_W'(p_ww_reg) + SUM_W'(p_xx_reg) - SUM_W'(p_yy_reg)
                  - SUM_W'(p_zz_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v2_reg <= 1'b0;
        else
            v2_reg <= v1_reg;
    end

    always_ff @(posedge clk)
    begin
        s2_reg  <= s_sat[S_W-1:0];
        py2_reg <= py_next;
        px2_reg <= px_next;
        yy2_reg <= yy_next;
        yx2_reg <= yx_next;
    end

    // Stage 3: radicand 2^60 - s^2; then one root bit per stage
    logic signed [63:0] s_sq;
    logic [63:0]        rad_full;

    assign s_sq     = s2_reg * s2_reg;
    assign rad_full = (64'd1 << 60) - $unsigned(s_sq);

    logic                    q_vld_reg [0:SQRT_N];
    logic [RES_W-1:0]        q_v_reg   [0:SQRT_N];
    logic [RES_W-1:0]        q_r_reg   [0:SQRT_N];
    logic signed [S_W-1:0]   q_s_reg   [0:SQRT_N];
    logic signed [SUM_W-1:0] q_py_reg  [0:SQRT_N];
    logic signed [SUM_W-1:0] q_px_reg  [0:SQRT_N];
    logic signed [SUM_W-1:0] q_yy_reg  [0:SQRT_N];
    logic signed [SUM_W-1:0] q_yx_reg  [0:SQRT_N];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            q_vld_reg[0] <= 1'b0;
        else
            q_vld_reg[0] <= v2_reg;
    end

    always_ff @(posedge clk)
    begin
        q_v_reg[0]  <= RES_W'(rad_full[SQ_W-1:0]);
        q_r_reg[0]  <= '0;
        q_s_reg[0]  <= s2_reg;
        q_py_reg[0] <= py2_reg;
        q_px_reg[0] <= px2_reg;
        q_yy_reg[0] <= yy2_reg;
        q_yx_reg[0] <= yx2_reg;
    end

    for (genvar t = 0; t < SQRT_N; t++)
    begin : g_sqrt
        localparam logic [RES_W-1:0] BIT_T = RES_W'(1) << (2 * (SQRT_N - 1 - t));
        logic [RES_W-1:0] trial;

        assign trial = q_r_reg[t] + BIT_T;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                q_vld_reg[t+1] <= 1'b0;
            else
                q_vld_reg[t+1] <= q_vld_reg[t];
        end

        // Try the next root bit; keep it if the remainder allows
        always_ff @(posedge clk)
        begin
            if (q_v_reg[t] >= trial)
            begin
                q_v_reg[t+1] <= q_v_reg[t] - trial;
                q_r_reg[t+1] <= (q_r_reg[t] >> 1) + BIT_T;
            end
            else
            begin
                q_v_reg[t+1] <= q_v_reg[t];
                q_r_reg[t+1] <= q_r_reg[t] >> 1;
            end
            q_s_reg[t+1]  <= q_s_reg[t];
            q_py_reg[t+1] <= q_py_reg[t];
            q_px_reg[t+1] <= q_px_reg[t];
            q_yy_reg[t+1] <= q_yy_reg[t];
            q_yx_reg[t+1] <= q_yx_reg[t];
        end
    end

    // Three matched angle pipelines
    logic signed [SUM_W-1:0] roll_y, roll_x;
    logic vr, vp, vy;

    assign roll_y = SUM_W'(q_s_reg[SQRT_N]);
    assign roll_x = $signed(q_r_reg[SQRT_N][SUM_W-1:0]);

    q2e_atan_deg #(
        .STEPS (CORDIC_STEPS),
        .FRAC  (ANGLE_FRAC_BITS),
        .OUT_W (24)
    ) u_roll (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (q_vld_reg[SQRT_N]),
        .in_y      (roll_y),
        .in_x      (roll_x),
        .out_valid (vr),
        .angle     (roll_deg)
    );

    q2e_atan_deg #(
        .STEPS (CORDIC_STEPS),
        .FRAC  (ANGLE_FRAC_BITS),
        .OUT_W (25)
    ) u_pitch (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (q_vld_reg[SQRT_N]),
        .in_y      (q_py_reg[SQRT_N]),
        .in_x      (q_px_reg[SQRT_N]),
        .out_valid (vp),
        .angle     (pitch_deg)
    );

    q2e_atan_deg #(
        .STEPS (CORDIC_STEPS),
        .FRAC  (ANGLE_FRAC_BITS),
        .OUT_W (25)
    ) u_yaw (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (q_vld_reg[SQRT_N]),
        .in_y      (q_yy_reg[SQRT_N]),
        .in_x      (q_yx_reg[SQRT_N]),
        .out_valid (vy),
        .angle     (yaw_deg)
    );

    assign done = vr && vp && vy;

endmodule
`default_nettype wire

FILE: hdl/q2e_atan_deg.sv
// Pipelined two-argument arctangent by CORDIC vectoring, scaled to saturated degrees.
`default_nettype none
module q2e_atan_deg
    import q2e_pkg::*;
#(
    parameter int STEPS = 24,
    parameter int FRAC  = 16,
    parameter int OUT_W = 25
)(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    in_valid,
    input  wire logic signed [SUM_W-1:0] in_y,
    input  wire logic signed [SUM_W-1:0] in_x,
    output logic                         out_valid,
    output logic signed [OUT_W-1:0]      angle
);

    localparam int AW     = ZW - 20;
    localparam int NW     = AW + 10;
    localparam int KSH    = 37 - FRAC;
    localparam int MW     = NW - KSH;
    localparam int DS     = (MW + 7) / 8;
    localparam int DW     = DS * 8;
    localparam int EW     = DW + OUT_W;
    localparam logic [NW-1:0] HALF_D = NW'(5) << (36 - FRAC);
    localparam logic [EW-1:0] LIM    = EW'(1) << (OUT_W - 1);

    // Prescale stage
    logic                   p0_vld_reg, p0_zero_reg;
    logic signed [PS_W-1:0] p0_x_reg, p0_y_reg;
    logic [PS_SEL_W-1:0]    sel;
    logic signed [SUM_W-1:0] x_sh, y_sh;

    always_comb
    begin
        sel = PS_SEL_W'(PS_MAX);
        for (int n = PS_MAX; n >= 0; n--)
        begin
            if (fits31(in_x >>> n) && fits31(in_y >>> n))
                sel = PS_SEL_W'(n);
        end
        x_sh = in_x >>> sel;
        y_sh = in_y >>> sel;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            p0_vld_reg <= 1'b0;
        else
            p0_vld_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        p0_zero_reg <= (in_x == '0) && (in_y == '0);
        p0_x_reg    <= x_sh[PS_W-1:0];
        p0_y_reg    <= y_sh[PS_W-1:0];
    end

    // CORDIC pipeline: index 0 is the half-plane fold, then one stage per step
    logic                 c_vld_reg  [0:STEPS];
    logic                 c_zero_reg [0:STEPS];
    logic signed [CW-1:0] c_x_reg    [0:STEPS];
    logic signed [CW-1:0] c_y_reg    [0:STEPS];
    logic signed [ZW-1:0] c_z_reg    [0:STEPS];

    // Fold a left-half-plane vector over and start from plus or minus pi
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            c_vld_reg[0] <= 1'b0;
        else
            c_vld_reg[0] <= p0_vld_reg;
    end

    always_ff @(posedge clk)
    begin
        c_zero_reg[0] <= p0_zero_reg;
        if (p0_x_reg < 0)
        begin
            c_x_reg[0] <= -CW'(p0_x_reg);
            c_y_reg[0] <= -CW'(p0_y_reg);
            c_z_reg[0] <= (p0_y_reg >= 0) ? PI_Q56 : -PI_Q56;
        end
        else
        begin
            c_x_reg[0] <= CW'(p0_x_reg);
            c_y_reg[0] <= CW'(p0_y_reg);
            c_z_reg[0] <= '0;
        end
    end

    for (genvar i = 0; i < STEPS; i++)
    begin : g_step
        localparam logic signed [ZW-1:0] ATAN_I = atan_q56(i);
        logic signed [CW-1:0] dx, dy;

        assign dx = c_y_reg[i] >>> i;
        assign dy = c_x_reg[i] >>> i;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                c_vld_reg[i+1] <= 1'b0;
            else
                c_vld_reg[i+1] <= c_vld_reg[i];
        end

        // Rotate toward the x axis
        always_ff @(posedge clk)
        begin
            c_zero_reg[i+1] <= c_zero_reg[i];
            if (c_y_reg[i] > 0)
            begin
                c_x_reg[i+1] <= c_x_reg[i] + dx;
                c_y_reg[i+1] <= c_y_reg[i] - dy;
                c_z_reg[i+1] <= c_z_reg[i] + ATAN_I;
            end
            else
            begin
                c_x_reg[i+1] <= c_x_reg[i] - dx;
                c_y_reg[i+1] <= c_y_reg[i] + dy;
                c_z_reg[i+1] <= c_z_reg[i] - ATAN_I;
            end
        end
    end

    // Degrees: round magnitude to Q36, scale by 573, fold in the divisor's power of two
    logic signed [ZW-1:0] zv;
    logic                 zneg;
    logic [ZW-1:0]        zabs, zrnd;
    logic [NW-1:0]        nprod;

    always_comb
    begin
        zv    = c_zero_reg[STEPS] ? '0 : c_z_reg[STEPS];
        zneg  = zv < 0;
        zabs  = zneg ? $unsigned(-zv) : $unsigned(zv);
        zrnd  = zabs + (ZW'(1) << 19);
        nprod = NW'(zrnd[ZW-1:20]) * NW'(573) + HALF_D;
    end

    logic          d_vld_reg [0:DS];
    logic          d_neg_reg [0:DS];
    logic [DW-1:0] d_q_reg   [0:DS];
    logic [2:0]    d_rem_reg [0:DS];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            d_vld_reg[0] <= 1'b0;
        else
            d_vld_reg[0] <= c_vld_reg[STEPS];
    end

    always_ff @(posedge clk)
    begin
        d_neg_reg[0] <= zneg;
        d_q_reg[0]   <= DW'(nprod[NW-1:KSH]);
        d_rem_reg[0] <= '0;
    end

    // Divide by five, eight quotient bits per stage
    for (genvar j = 0; j < DS; j++)
    begin : g_div
        logic [DW-1:0] q_n;
        logic [3:0]    r;

        always_comb
        begin
            q_n = d_q_reg[j];
            r   = {1'b0, d_rem_reg[j]};
            for (int b = DW - 1 - 8 * j; b > DW - 9 - 8 * j; b--)
            begin
                r = {r[2:0], d_q_reg[j][b]};
                if (r >= 4'd5)
                begin
                    r      = r - 4'd5;
                    q_n[b] = 1'b1;
                end
                else
                begin
                    q_n[b] = 1'b0;
                end
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                d_vld_reg[j+1] <= 1'b0;
            else
                d_vld_reg[j+1] <= d_vld_reg[j];
        end

        always_ff @(posedge clk)
        begin
            d_neg_reg[j+1] <= d_neg_reg[j];
            d_q_reg[j+1]   <= q_n;
            d_rem_reg[j+1] <= r[2:0];
        end
    end

    // Saturate to the field and apply the sign
    logic [EW-1:0]        qe, qs;
    logic                 out_vld_reg;
    logic signed [OUT_W-1:0] angle_reg, angle_next;

    always_comb
    begin
        qe = EW'(d_q_reg[DS]);
        if (d_neg_reg[DS])
        begin
            qs         = (qe > LIM) ? LIM : qe;
            angle_next = -$signed(qs[OUT_W-1:0]);
        end
        else
        begin
            qs         = (qe > LIM - EW'(1)) ? LIM - EW'(1) : qe;
            angle_next = $signed(qs[OUT_W-1:0]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_vld_reg <= 1'b0;
        else
            out_vld_reg <= d_vld_reg[DS];
    end

    always_ff @(posedge clk)
    begin
        angle_reg <= angle_next;
    end

    assign out_valid = out_vld_reg;
    assign angle     = angle_reg;

endmodule
`default_nettype wire

FILE: sim/tb_quaternion_to_euler_angles_top.sv
// Testbench for the quaternion-to-Euler block: self-checking, with a bit-exact angle predictor.
`timescale 1ns / 100ps
module tb_quaternion_to_euler_angles_top;

    localparam int STEPS     = 24;
    localparam int FRAC      = 16;
    localparam int LATENCY   = 66;
    localparam int N_RANDOM  = 800;
    localparam int MAX_CYCLE = 400000;

    typedef struct packed {
        logic               present;
        logic signed [31:0] w;
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
    } quat_beat_t;

    typedef struct packed {
        logic signed [23:0] roll;
        logic signed [24:0] pitch;
        logic signed [24:0] yaw;
    } euler_t;

    logic               clk;
    logic               rst_n;
    logic               start;
    logic               busy;
    logic               quat_present;
    logic signed [31:0] quat_w;
    logic signed [31:0] quat_x;
    logic signed [31:0] quat_y;
    logic signed [31:0] quat_z;
    logic               done;
    logic signed [23:0] roll_deg;
    logic signed [24:0] pitch_deg;
    logic signed [24:0] yaw_deg;

    quat_beat_t  pending_q[$];
    euler_t      angles_q[$];
    logic        hold_off;
    logic        no_gaps;
    logic        stim_done;
    int          n_fail;
    int          cycle_cnt;
    longint      atan_tab[0:63];

    quaternion_to_euler_angles_top #(
        .CORDIC_STEPS    (STEPS),
        .ANGLE_FRAC_BITS (FRAC)
    ) i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .quat_present (quat_present),
        .quat_w       (quat_w),
        .quat_x       (quat_x),
        .quat_y       (quat_y),
        .quat_z       (quat_z),
        .done         (done),
        .roll_deg     (roll_deg),
        .pitch_deg    (pitch_deg),
        .yaw_deg      (yaw_deg)
    );

    // Floor product of two Q30 values
    function automatic longint qmul(longint a, longint b);
        return (a * b) >>> 30;
    endfunction

    // Build the per-step arctangent table in Q56 from the power series in Q62
    function automatic longint step_angle(int i);
        longint acc;
        longint term;
        int     e;
        acc = 0;
        if (i == 0)
            return 64'sh00C90FDAA22168C2;
        for (int k = 0; k < 64; k++)
        begin
            e = 62 - i * (2 * k + 1);
            if (e >= 0)
            begin
                term = longint'((64'd1 << e) / longint'(2 * k + 1));
                acc = (k % 2 == 1) ? acc - term : acc + term;
            end
        end
        return (acc + 32) >>> 6;
    endfunction

    // Vectoring CORDIC: angle of (xv, yv) in Q56 radians
    function automatic longint vec_angle(longint yv, longint xv);
        longint ang;
        longint dx;
        longint dy;
        ang = 0;
        if (xv == 0 && yv == 0)
            return 0;
        while (xv >= (64'sd1 <<< 31) || xv <= -(64'sd1 <<< 31)
               || yv >= (64'sd1 <<< 31) || yv <= -(64'sd1 <<< 31))
        begin
            xv = xv >>> 1;
            yv = yv >>> 1;
        end
        if (xv < 0)
        begin
            ang = (yv >= 0) ? 64'sh03243F6A8885A309 : -64'sh03243F6A8885A309;
            xv  = -xv;
            yv  = -yv;
        end
        for (int i = 0; i < STEPS; i++)
        begin
            dx = yv >>> i;
            dy = xv >>> i;
            if (yv > 0)
            begin
                xv  = xv + dx;
                yv  = yv - dy;
                ang = ang + atan_tab[i];
            end
            else
            begin
                xv  = xv - dx;
                yv  = yv + dy;
                ang = ang - atan_tab[i];
            end
        end
        return ang;
    endfunction

    // Integer square root, bit by bit
    function automatic longint int_sqrt(longint unsigned v);
        longint unsigned res;
        longint unsigned bt;
        res = 0;
        bt  = 64'd1 << 62;
        while (bt > v)
            bt = bt >> 2;
        while (bt != 0)
        begin
            if (v >= res + bt)
            begin
                v   = v - (res + bt);
                res = (res >> 1) + bt;
            end
            else
                res = res >> 1;
            bt = bt >> 2;
        end
        return longint'(res);
    endfunction

    // Radians Q56 to saturated degrees with FRAC fraction bits
    function automatic longint deg_scale(longint ang, int width);
        longint unsigned a;
        longint unsigned d;
        longint unsigned q;
        longint unsigned lim;
        a   = (ang < 0) ? longint'(-ang) : longint'(ang);
        d   = 64'd10 << (36 - FRAC);
        lim = 64'd1 << (width - 1);
        a   = (a + (64'd1 << 19)) >> 20;
        q   = (a * 573 + d / 2) / d;
        if (ang < 0)
        begin
            if (q > lim)
                q = lim;
            return -longint'(q);
        end
        if (q > lim - 1)
            q = lim - 1;
        return longint'(q);
    endfunction

    // Work out the three angles of one quaternion
    function automatic euler_t predict_angles(quat_beat_t b);
        longint w, x, y, z, s, c, py, px, yy, yx;
        euler_t r;
        w = b.w;
        x = b.x;
        y = b.y;
        z = b.z;
        s = 2 * (qmul(w, y) - qmul(x, z));
        if (s > (64'sd1 <<< 30))
            s = 64'sd1 <<< 30;
        if (s < -(64'sd1 <<< 30))
            s = -(64'sd1 <<< 30);
        c  = int_sqrt(longint'((64'd1 << 60) - longint'(s * s)));
        py = 2 * (qmul(y, z) + qmul(w, x));
        px = (64'sd1 <<< 30) - 2 * (qmul(x, x) + qmul(y, y));
        yy = 2 * (qmul(x, y) + qmul(w, z));
        yx = qmul(w, w) + qmul(x, x) - qmul(y, y) - qmul(z, z);
        r.roll  = 24'(deg_scale(vec_angle(s, c), 24));
        r.pitch = 25'(deg_scale(vec_angle(py, px), 25));
        r.yaw   = 25'(deg_scale(vec_angle(yy, yx), 25));
        return r;
    endfunction

    function automatic logic signed [31:0] rand_comp();
        case ($urandom_range(0, 5))
            0: return 32'sd1073741824;
            1: return -32'sd1073741824;
            2: return 32'sd0;
            3: return $signed($urandom());
            default: return $signed(32'($urandom_range(0, 32'h7FFF_FFFF)) - 32'sh4000_0000);
        endcase
    endfunction

    function automatic quat_beat_t make_beat(int p, int w, int x, int y, int z);
        quat_beat_t b;
        b.present = (p != 0);
        b.w = w;
        b.x = x;
        b.y = y;
        b.z = z;
        return b;
    endfunction

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Stimulus
    initial
    begin
        quat_beat_t b;
        int         one;
        int         h;
        for (int i = 0; i < 64; i++)
            atan_tab[i] = step_angle(i);
        one       = 1073741824;
        h         = 759250125;
        rst_n     = 1'b0;
        hold_off  = 1'b0;
        no_gaps   = 1'b0;
        stim_done = 1'b0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: identity, axes, pole cases, zeros, bit extremes, absent items
        pending_q.push_back(make_beat(1, one, 0, 0, 0));
        pending_q.push_back(make_beat(1, -one, 0, 0, 0));
        pending_q.push_back(make_beat(1, 0, one, 0, 0));
        pending_q.push_back(make_beat(1, 0, 0, one, 0));
        pending_q.push_back(make_beat(1, 0, 0, 0, one));
        pending_q.push_back(make_beat(1, h, 0, h, 0));
        pending_q.push_back(make_beat(1, h, 0, -h, 0));
        pending_q.push_back(make_beat(1, 0, 0, 0, 0));
        pending_q.push_back(make_beat(0, one, one, one, one));
        pending_q.push_back(make_beat(1, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF,
                                      32'h7FFFFFFF));
        pending_q.push_back(make_beat(1, 32'h80000000, 32'h80000000, 32'h80000000,
                                      32'h80000000));
        pending_q.push_back(make_beat(1, 32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF,
                                      32'h80000000));
        pending_q.push_back(make_beat(1, -1, -1, -1, -1));
        pending_q.push_back(make_beat(1, h, h, 0, 0));
        pending_q.push_back(make_beat(1, 0, 0, h, -h));
        pending_q.push_back(make_beat(1, 0, -h, 0, h));
        pending_q.push_back(make_beat(1, one / 2, one / 2, one / 2, one / 2));
        pending_q.push_back(make_beat(1, -one / 2, one / 2, -one / 2, one / 2));
        pending_q.push_back(make_beat(0, 0, 0, 0, 0));
        wait (pending_q.size() == 0);

        // Pause the sender until every pending result has come back
        @(negedge clk);
        hold_off = 1'b1;
        wait (angles_q.size() == 0);
        @(negedge clk);
        hold_off = 1'b0;

        // Random, with a gap-free stretch in the middle
        for (int n = 0; n < N_RANDOM; n++)
        begin
            if (n == 300)
            begin
                wait (pending_q.size() == 0);
                no_gaps = 1'b1;
            end
            if (n == 500)
            begin
                wait (pending_q.size() == 0);
                no_gaps = 1'b0;
            end
            b.present = ($urandom_range(0, 9) != 0);
            b.w = rand_comp();
            b.x = rand_comp();
            b.y = rand_comp();
            b.z = rand_comp();
            pending_q.push_back(b);
        end
        wait (pending_q.size() == 0);
        stim_done = 1'b1;
    end

    // Driver: present a beat at the falling edge, drop it once accepted
    always @(negedge clk)
    begin
        if (rst_n && start && !busy)
            void'(pending_q.pop_front());
        if (rst_n && !hold_off && pending_q.size() > 0
            && (no_gaps || $urandom_range(0, 99) >= 32))
        begin
            start        <= 1'b1;
            quat_present <= pending_q[0].present;
            quat_w       <= pending_q[0].w;
            quat_x       <= pending_q[0].x;
            quat_y       <= pending_q[0].y;
            quat_z       <= pending_q[0].z;
        end
        else
        begin
            start        <= 1'b0;
            quat_present <= 1'($urandom_range(0, 1));
            quat_w       <= $urandom();
            quat_x       <= $urandom();
            quat_y       <= $urandom();
            quat_z       <= $urandom();
        end
    end

    initial
    begin
        start        = 1'b0;
        quat_present = 1'b0;
        quat_w       = '0;
        quat_x       = '0;
        quat_y       = '0;
        quat_z       = '0;
    end

    // Monitor: predict on accepted beats, check result beats
    always @(posedge clk)
    begin
        euler_t exp_a;
        quat_beat_t b;
        if (rst_n)
        begin
            if (done)
            begin
                if (angles_q.size() == 0)
                begin
                    $error("unexpected result beat roll=%0d pitch=%0d yaw=%0d",
                           roll_deg, pitch_deg, yaw_deg);
                    n_fail = n_fail + 1;
                end
                else
                begin
                    exp_a = angles_q.pop_front();
                    if (roll_deg !== exp_a.roll)
                    begin
                        $error("roll_deg expected %0d actual %0d", exp_a.roll, roll_deg);
                        n_fail = n_fail + 1;
                    end
                    if (pitch_deg !== exp_a.pitch)
                    begin
                        $error("pitch_deg expected %0d actual %0d", exp_a.pitch, pitch_deg);
                        n_fail = n_fail + 1;
                    end
                    if (yaw_deg !== exp_a.yaw)
                    begin
                        $error("yaw_deg expected %0d actual %0d", exp_a.yaw, yaw_deg);
                        n_fail = n_fail + 1;
                    end
                end
            end
            if (start && !busy && quat_present)
            begin
                b = make_beat(1, quat_w, quat_x, quat_y, quat_z);
                angles_q.push_back(predict_angles(b));
            end
        end
    end

    initial
    begin
        n_fail = 0;
    end

    // Watchdog
    initial
    begin
        cycle_cnt = 0;
        forever
        begin
            @(posedge clk);
            cycle_cnt = cycle_cnt + 1;
            if (cycle_cnt > MAX_CYCLE)
            begin
                $display("** quaternion_to_euler_angles_top: FAILED **");
                $finish;
            end
        end
    end

    // End of run
    initial
    begin
        wait (stim_done);
        wait (angles_q.size() == 0);
        repeat (LATENCY + 10) @(posedge clk);
        if (n_fail == 0 && angles_q.size() == 0)
            $display("** quaternion_to_euler_angles_top: PASSED **");
        else
            $display("** quaternion_to_euler_angles_top: FAILED **");
        $finish;
    end

endmodule
